[hdl/dat_pkg.sv]
// Shared types, constants and helper functions for the device address table.
package dat_pkg;

    // Configured number of table entries.
    localparam int ENTRIES = 256;

    // Ids are 8 bits wide, so no entry at or above 256 can ever be reached.
    localparam int DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
    localparam int IDX_W = $clog2(DEPTH);

    // The allocate scan looks at this many occupancy bits per cycle.
    localparam int CHUNK  = (DEPTH < 16) ? DEPTH : 16;
    localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
    localparam int OCC_W  = NCHUNK * CHUNK;
    localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int POS_W  = (CHUNK > 1) ? $clog2(CHUNK) : 1;

    // Operation codes.
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_ALLOC  = 2'd1;
    localparam logic [1:0] FUNC_INSERT = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;
    localparam logic [7:0]  FULL_ID    = 8'd255;

    // One request.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  id;
        logic [31:0] device_addr;
    } req_t;

    // One result.
    typedef struct packed {
        logic [31:0] result_addr;
        logic [7:0]  result_id;
        logic [1:0]  status;
    } rsp_t;

    // Outcome of a search over one group of occupancy bits.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } find_t;

    // An entry holding zero or all ones counts as empty.
    function automatic logic slot_empty(input logic [31:0] v);
        return (v == 32'd0) || (v == EMPTY_WORD);
    endfunction

    // Ids that allocate may hand out: 1 to 254, and only those inside the table.
    function automatic logic [OCC_W-1:0] alloc_mask();
        logic [OCC_W-1:0] m;
        m = '0;
        for (int i = 0; i < OCC_W; i++)
        begin
            m[i] = (i >= 1) && (i <= 254) && (i < DEPTH);
        end
        return m;
    endfunction

endpackage

[hdl/dat_find.sv]
// Finds the lowest free id within one group of occupancy bits.
module dat_find
(
    input  logic [dat_pkg::CHUNK-1:0] free_mask,
    output dat_pkg::find_t            hit
);

    // Priority encoder: lowest set bit wins.
    always_comb
    begin
        hit = '0;
        for (int i = dat_pkg::CHUNK - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                hit.found = 1'b1;
                hit.pos   = dat_pkg::POS_W'(i);
            end
        end
    end

endmodule

[hdl/device_address_table.sv]
// Top level of the device address table: address memory, occupancy bits and sequencer.
//
// The table holds one 32-bit device address per 8-bit id in a synchronous RAM, with one
// occupancy flip-flop per entry that reset clears, so every entry reads as empty right after
// reset without a clearing pass. A request is taken when start is high and busy is low; its
// result appears on rsp for exactly one cycle with done high and must be captured then, since
// the table cannot be held off. An insert writes the RAM in the cycle it is accepted, and a
// lookup makes one RAM read. An allocate walks the 16-id groups of occupancy bits in order
// until a free id is found, at most 16 groups for a 256-entry table.
module device_address_table
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  dat_pkg::req_t req,
    output logic          done,
    output dat_pkg::rsp_t rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    localparam logic [dat_pkg::OCC_W-1:0] ALLOC_MASK = dat_pkg::alloc_mask();

    logic [1:0]                 state_reg, state_next;
    logic [dat_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]                 id_reg, id_next;
    logic [31:0]                dev_reg, dev_next;
    logic                       hit_reg, hit_next;
    logic                       done_reg, done_next;
    dat_pkg::rsp_t              rsp_reg, rsp_next;
    logic [dat_pkg::DEPTH-1:0]  occ_reg;

    logic [31:0]                mem [dat_pkg::DEPTH];
    logic [31:0]                rdata_reg;

    logic                       accept;
    logic                       in_range;
    logic [dat_pkg::IDX_W-1:0]  req_idx;
    logic                       we;
    logic [dat_pkg::IDX_W-1:0]  waddr;
    logic [31:0]                wdata;
    logic [dat_pkg::OCC_W-1:0]  occ_pad;
    logic [dat_pkg::CHUNK-1:0]  free_mask;
    dat_pkg::find_t             hit;
    logic [7:0]                 found_id;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign in_range = (9'(req.id) < 9'(dat_pkg::DEPTH));
    assign req_idx  = dat_pkg::IDX_W'(req.id);

    // Free ids in the group of occupancy bits under the scan pointer.
    assign occ_pad   = dat_pkg::OCC_W'(occ_reg);
    assign free_mask = ~occ_pad[cnt_reg * dat_pkg::CHUNK +: dat_pkg::CHUNK]
                     & ALLOC_MASK[cnt_reg * dat_pkg::CHUNK +: dat_pkg::CHUNK];

    dat_find u_find
    (
        .free_mask (free_mask),
        .hit       (hit)
    );

    assign found_id = 8'(32'(cnt_reg) * dat_pkg::CHUNK + 32'(hit.pos));

    // Sequencer: issues reads and writes, walks occupancy groups and forms the result.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        dev_next   = dev_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        we         = 1'b0;
        waddr      = req_idx;
        wdata      = req.device_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next  = req.id;
                    dev_next = req.device_addr;
                    hit_next = in_range && occ_reg[req_idx];
                    unique case (req.func)
                        dat_pkg::FUNC_ALLOC:
                        begin
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        dat_pkg::FUNC_INSERT:
                        begin
                            we                   = in_range;
                            done_next            = 1'b1;
                            rsp_next.result_addr = req.device_addr;
                            rsp_next.result_id   = req.id;
                            rsp_next.status      = in_range ? dat_pkg::STAT_OK
                                                            : dat_pkg::STAT_NOT_FOUND;
                        end
                        default:
                        begin
                            state_next = S_LOOK;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                done_next            = 1'b1;
                rsp_next.result_addr = hit_reg ? rdata_reg : 32'd0;
                rsp_next.result_id   = id_reg;
                rsp_next.status      = hit_reg ? dat_pkg::STAT_OK : dat_pkg::STAT_NOT_FOUND;
                state_next           = S_IDLE;
            end
            S_SCAN:
            begin
                if (hit.found)
                begin
                    we                   = 1'b1;
                    waddr                = dat_pkg::IDX_W'(found_id);
                    wdata                = dev_reg;
                    done_next            = 1'b1;
                    rsp_next.result_addr = dev_reg;
                    rsp_next.result_id   = found_id;
                    rsp_next.status      = dat_pkg::STAT_OK;
                    state_next           = S_IDLE;
                end
                else if (cnt_reg == dat_pkg::CNT_W'(dat_pkg::NCHUNK - 1))
                begin
                    done_next            = 1'b1;
                    rsp_next.result_addr = 32'd0;
                    rsp_next.result_id   = dat_pkg::FULL_ID;
                    rsp_next.status      = dat_pkg::STAT_FULL;
                    state_next           = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and occupancy bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (we)
            begin
                occ_reg[waddr] <= !dat_pkg::slot_empty(wdata);
            end
        end
    end

    // Request and result holding registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        id_reg  <= id_next;
        dev_reg <= dev_next;
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end

    // Address memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[req_idx];
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // No result is presented while a scan is still walking the occupancy bits.
    a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !done)
        else $error("result presented during allocate scan");

    // An accepted allocate always starts a scan.
    a_alloc_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == dat_pkg::FUNC_ALLOC) |=> (state_reg == S_SCAN))
        else $error("allocate did not start a scan");

    // A full table reports id 255 and address zero.
    a_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == dat_pkg::STAT_FULL)
        |-> (rsp.result_id == dat_pkg::FULL_ID && rsp.result_addr == 32'd0))
        else $error("full status with wrong id or address");

    // A successful allocate hands out an id from 1 to 254.
    a_alloc_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(state_reg == S_SCAN) && rsp.status == dat_pkg::STAT_OK)
        |-> (rsp.result_id != 8'd0 && rsp.result_id != dat_pkg::FULL_ID))
        else $error("allocate returned a reserved id");

    // A lookup hit never returns an empty-looking address.
    a_look_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(state_reg == S_LOOK) && rsp.status == dat_pkg::STAT_OK)
        |-> !dat_pkg::slot_empty(rsp.result_addr))
        else $error("lookup hit returned an empty entry");

endmodule

[test/device_address_table_tb.sv]
// Testbench for device_address_table: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module device_address_table_tb;

    // Operation code the block does not define; it behaves as a lookup.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    dat_pkg::req_t  req;
    logic           done;
    dat_pkg::rsp_t  rsp;

    // Predicted copy of the address store and the replies still owed by the block.
    logic [31:0]    shadow_addr [0:255];
    dat_pkg::rsp_t  pending_replies [$];

    int fail_count;
    int sender_idle_pct;

    device_address_table u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Zero and all ones both mark a free entry.
    function automatic logic is_vacant(input logic [31:0] word);
        return (word == 32'd0) || (word == dat_pkg::EMPTY_WORD);
    endfunction

    // Applies one request to the shadow store and returns the reply it must produce.
    function automatic dat_pkg::rsp_t model_table_access(input dat_pkg::req_t r);
        dat_pkg::rsp_t o;
        logic          in_range;
        logic          found;
        logic [31:0]   word;
        int            slot;
        o.result_addr = 32'd0;
        o.result_id   = r.id;
        o.status      = dat_pkg::STAT_OK;
        in_range      = (int'(r.id) < dat_pkg::ENTRIES);
        case (r.func)
            dat_pkg::FUNC_ALLOC:
            begin
                found = 1'b0;
                for (int i = 1; i < int'(dat_pkg::FULL_ID) && i < dat_pkg::ENTRIES; i++)
                begin
                    if (!found && is_vacant(shadow_addr[i]))
                    begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (found)
                begin
                    shadow_addr[slot] = r.device_addr;
                    o.result_addr     = r.device_addr;
                    o.result_id       = slot[7:0];
                end
                else
                begin
                    o.result_id = dat_pkg::FULL_ID;
                    o.status    = dat_pkg::STAT_FULL;
                end
            end
            dat_pkg::FUNC_INSERT:
            begin
                o.result_addr = r.device_addr;
                if (in_range)
                    shadow_addr[r.id] = r.device_addr;
                else
                    o.status = dat_pkg::STAT_NOT_FOUND;
            end
            default:
            begin
                // Lookup, and the unused code that falls back to it.
                word = in_range ? shadow_addr[r.id] : 32'd0;
                if (is_vacant(word))
                    o.status = dat_pkg::STAT_NOT_FOUND;
                else
                    o.result_addr = word;
            end
        endcase
        return o;
    endfunction

    // Sends one request after a random gap; returns at the edge that accepts it.
    task automatic send_request(input logic [1:0] f, input logic [7:0] dev_id,
                                input logic [31:0] addr);
        dat_pkg::req_t r;
        r.func        = f;
        r.id          = dev_id;
        r.device_addr = addr;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_replies.push_back(model_table_access(r));
    endtask

    // Holds off new requests until every owed reply has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Each reply is compared with the oldest prediction in the middle of its cycle.
    always @(negedge clk)
    begin
        dat_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                if (fail_count < 10)
                    $display("ERROR: unexpected reply addr=%h id=%0d status=%0d",
                             rsp.result_addr, rsp.result_id, rsp.status);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.result_addr !== want.result_addr || rsp.result_id !== want.result_id
                    || rsp.status !== want.status)
                begin
                    if (fail_count < 10)
                        $display("ERROR: got addr=%h id=%0d st=%0d, want addr=%h id=%0d st=%0d",
                                 rsp.result_addr, rsp.result_id, rsp.status,
                                 want.result_addr, want.result_id, want.status);
                    fail_count++;
                end
            end
        end
    end

    // Entries 0, 1, 128 and 255 must read as missing right after reset.
    task automatic test_lookup_after_reset();
        send_request(dat_pkg::FUNC_LOOKUP, 8'd0, 32'hFFFF_FFFF);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd255, 32'd0);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd1, 32'h1234_5678);
        send_request(FUNC_UNUSED, 8'd128, 32'hDEAD_BEEF);
    endtask

    // Inserts at the id extremes, empty-looking values, updates and the unused code.
    task automatic test_insert_and_lookup();
        send_request(dat_pkg::FUNC_INSERT, 8'd0, 32'hA5A5_A5A5);
        send_request(dat_pkg::FUNC_INSERT, 8'd255, 32'hFFFF_FFFE);
        send_request(dat_pkg::FUNC_INSERT, 8'd9, 32'h0000_0001);
        send_request(dat_pkg::FUNC_INSERT, 8'd10, 32'h0000_0000);
        send_request(dat_pkg::FUNC_INSERT, 8'd11, 32'hFFFF_FFFF);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd0, 32'd0);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd255, 32'd0);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd9, 32'd0);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd10, 32'd0);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd11, 32'd0);
        send_request(FUNC_UNUSED, 8'd9, 32'hFFFF_FFFF);
        send_request(dat_pkg::FUNC_INSERT, 8'd0, 32'h5A5A_5A5A);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd0, 32'd0);
    endtask

    // Allocation takes the lowest free id and reuses entries freed by an insert.
    task automatic test_allocate_order();
        send_request(dat_pkg::FUNC_ALLOC, 8'd77, 32'h1111_1111);
        send_request(dat_pkg::FUNC_ALLOC, 8'd0, 32'h0000_0000);
        send_request(dat_pkg::FUNC_ALLOC, 8'd255, 32'h2222_2222);
        send_request(dat_pkg::FUNC_INSERT, 8'd1, 32'hFFFF_FFFF);
        send_request(dat_pkg::FUNC_ALLOC, 8'd3, 32'h3333_3333);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd1, 32'd0);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd2, 32'd0);
    endtask

    // Fills the table by allocation, checks the full case, then frees two entries and allocates again.
    task automatic test_table_full();
        logic [31:0] addr;
        wait_drained();
        repeat (260)
        begin
            addr = $urandom();
            if (is_vacant(addr))
                addr = 32'h0000_0001;
            send_request(dat_pkg::FUNC_ALLOC, 8'($urandom_range(255)), addr);
        end
        send_request(dat_pkg::FUNC_INSERT, 8'd200, 32'h0000_0000);
        send_request(dat_pkg::FUNC_INSERT, 8'd17, 32'hFFFF_FFFF);
        send_request(dat_pkg::FUNC_ALLOC, 8'd0, 32'hCAFE_0017);
        send_request(dat_pkg::FUNC_ALLOC, 8'd0, 32'hCAFE_00C8);
        send_request(dat_pkg::FUNC_ALLOC, 8'd0, 32'hCAFE_FFFF);
        send_request(dat_pkg::FUNC_LOOKUP, 8'd200, 32'd0);
    endtask

    // Random mix; inserts often write empty-looking values so allocation keeps finding room.
    task automatic test_random_traffic(input int idle_pct, input int count);
        int          pick;
        int          vpick;
        logic [1:0]  f;
        logic [7:0]  dev_id;
        logic [31:0] addr;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                f = dat_pkg::FUNC_LOOKUP;
            else if (pick < 55)
                f = dat_pkg::FUNC_ALLOC;
            else if (pick < 90)
                f = dat_pkg::FUNC_INSERT;
            else
                f = FUNC_UNUSED;
            if ($urandom_range(1) == 0)
                dev_id = 8'($urandom_range(31));
            else
                dev_id = 8'($urandom_range(255));
            vpick = $urandom_range(99);
            if (f == dat_pkg::FUNC_INSERT && vpick < 20)
                addr = 32'd0;
            else if (f == dat_pkg::FUNC_INSERT && vpick < 40)
                addr = dat_pkg::EMPTY_WORD;
            else if (vpick < 5)
                addr = 32'd0;
            else if (vpick < 10)
                addr = dat_pkg::EMPTY_WORD;
            else
                addr = $urandom();
            send_request(f, dev_id, addr);
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req             = '0;
        fail_count      = 0;
        sender_idle_pct = 6;
        for (int i = 0; i < 256; i++)
            shadow_addr[i] = dat_pkg::EMPTY_WORD;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lookup_after_reset();
        test_insert_and_lookup();
        test_allocate_order();
        test_table_full();
        test_random_traffic(6, 170);
        wait_drained();
        test_random_traffic(71, 170);
        wait_drained();
        test_random_traffic(0, 170);
        wait_drained();
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/dat_pkg.sv
hdl/dat_find.sv
hdl/device_address_table.sv
test/device_address_table_tb.sv
